/* hdl/lfu_cache_lru_tiebreak_top_assert.svh */
// Assertion macros for the cache checker
`ifndef LFU_CACHE_LRU_TIEBREAK_TOP_ASSERT_SVH
`define LFU_CACHE_LRU_TIEBREAK_TOP_ASSERT_SVH
`define LFU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define LFU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

/* hdl/lfu_pkg.sv */
package lfu_pkg;
	localparam int ENTRIES_DEF = 16;
	localparam int KEY_W = 31;
	localparam int VAL_W = 31;
	localparam int CNT_W = 32;
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	typedef struct packed {
		logic action;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic hit;
		logic [VAL_W-1:0] data;
	} rsp_t;
endpackage

/* hdl/lfu_store.sv */
// Slot memory: one synchronous-read RAM holding key, value, count and rank per slot.
module lfu_store #(
	parameter int ENTRIES = lfu_pkg::ENTRIES_DEF,
	parameter int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	parameter int RNK_W = IDX_W,
	parameter int W = lfu_pkg::KEY_W + lfu_pkg::VAL_W + lfu_pkg::CNT_W + RNK_W
) (
	input  logic clk,
	input  logic we,
	input  logic [IDX_W-1:0] waddr,
	input  logic [W-1:0] wdata,
	input  logic [IDX_W-1:0] raddr,
	output logic [W-1:0] rdata
);
	logic [W-1:0] mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* hdl/lfu_cache_lru_tiebreak_top.sv */
// Steps from input beat to result valid when slots are rewritten: scan, decide, rank pass,
// write, output; when nothing changes: scan, decide, output.
// One item at a time: a new request waits until the last result has been taken;
// the single RAM port and the held result beat set the pace.
// Pass 1 reads every slot for the key match, the victim and a free slot; pass 2 rewrites ranks.
// Reset clears valid bits, occupancy and control; capacity resets to 16.
module lfu_cache_lru_tiebreak_top #(
	parameter int ENTRIES = lfu_pkg::ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [lfu_pkg::CAP_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  lfu_pkg::req_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output lfu_pkg::rsp_t out_data
);
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int KW = lfu_pkg::KEY_W;
	localparam int VW = lfu_pkg::VAL_W;
	localparam int NW = lfu_pkg::CNT_W;
	localparam int RW = IDX_W;
	localparam int W = KW + VW + NW + RW;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);
	localparam logic [IDX_W:0] CNT_END = (IDX_W + 1)'(ENTRIES);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SCAN = 6'b000010,
		S_DEC  = 6'b000100,
		S_FIX  = 6'b001000,
		S_WR   = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t state_q;
	lfu_pkg::req_t req_q;
	logic [lfu_pkg::CAP_W-1:0] cap_q;
	logic [ENTRIES-1:0] valid_q;
	logic [CW-1:0] occ_q;
	logic [IDX_W-1:0] ra_q, pa_s1;
	logic rv_s1, last_s1;
	logic hit_q, vic_ok_q, free_ok_q, rd_s1;
	logic [IDX_W-1:0] hidx_q, vidx_q, fidx_q, tgt_q;
	logic [NW-1:0] vcnt_q, hcnt_q;
	logic [RW-1:0] vrnk_q, trnk_q;
	logic [VW-1:0] hval_q;
	logic act_q, evict_q, ins_q;
	logic [IDX_W:0] cnt_q;
	lfu_pkg::rsp_t rsp_q;
	logic ov_q;

	logic we;
	logic [IDX_W-1:0] wa;
	logic [W-1:0] wd, rd;
	logic [KW-1:0] r_key;
	logic [VW-1:0] r_val;
	logic [NW-1:0] r_cnt;
	logic [RW-1:0] r_rnk;
	logic [lfu_pkg::CAP_W-1:0] cap_eff;

	assign {r_key, r_val, r_cnt, r_rnk} = rd;
	assign cap_eff = (32'(cap_q) > ENTRIES) ? lfu_pkg::CAP_W'(ENTRIES) : cap_q;

	lfu_store #(.ENTRIES(ENTRIES), .IDX_W(IDX_W), .RNK_W(RW), .W(W)) u_store (
		.clk(clk), .we(we), .waddr(wa), .wdata(wd), .raddr(ra_q), .rdata(rd)
	);

	assign in_ready = (state_q == S_IDLE) && !ov_q;
	assign out_valid = ov_q;
	assign out_data = rsp_q;

	// rank rewrite for slot pa_s1 in fix pass
	logic [RW-1:0] new_rnk;
	logic fix_we;
	always_comb begin
		new_rnk = r_rnk;
		fix_we = 1'b0;
		if (rv_s1 && pa_s1 != tgt_q) begin
			if (act_q) begin
				fix_we = 1'b1;
				if (evict_q && r_rnk > vrnk_q) begin
					new_rnk = r_rnk;
				end else begin
					new_rnk = r_rnk + RW'(1);
				end
			end else if (r_rnk < trnk_q) begin
				fix_we = 1'b1;
				new_rnk = r_rnk + RW'(1);
			end
		end
	end

	always_comb begin
		we = 1'b0;
		wa = pa_s1;
		wd = {r_key, r_val, r_cnt, new_rnk};
		if (state_q == S_FIX && rd_s1 && fix_we) begin
			we = 1'b1;
		end else if (state_q == S_WR) begin
			we = 1'b1;
			wa = tgt_q;
			if (ins_q) begin
				wd = {req_q.key, req_q.value, NW'(1), RW'(0)};
			end else begin
				wd = {req_q.key, (req_q.action == lfu_pkg::ACT_PUT) ? req_q.value : hval_q,
					(hcnt_q == '1) ? hcnt_q : hcnt_q + NW'(1), RW'(0)};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cap_q <= lfu_pkg::CAP_RESET;
			valid_q <= '0;
			occ_q <= '0;
			ov_q <= 1'b0;
			rd_s1 <= 1'b0;
			ra_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (ov_q && out_ready) begin
				ov_q <= 1'b0;
			end
			rd_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && !ov_q) begin
						req_q <= in_data;
						ra_q <= '0;
						cnt_q <= '0;
						hit_q <= 1'b0;
						vic_ok_q <= 1'b0;
						free_ok_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (cnt_q != CNT_END) begin
						if (ra_q != LAST) begin
							ra_q <= ra_q + IDX_W'(1);
						end
						cnt_q <= cnt_q + (IDX_W + 1)'(1);
						rd_s1 <= 1'b1;
					end
					if (rd_s1) begin
						if (rv_s1) begin
							if (r_key == req_q.key) begin
								hit_q <= 1'b1;
								hidx_q <= pa_s1;
								hval_q <= r_val;
								hcnt_q <= r_cnt;
								trnk_q <= r_rnk;
							end
							if (!vic_ok_q || r_cnt < vcnt_q ||
								(r_cnt == vcnt_q && r_rnk > vrnk_q)) begin
								vic_ok_q <= 1'b1;
								vidx_q <= pa_s1;
								vcnt_q <= r_cnt;
								vrnk_q <= r_rnk;
							end
						end else if (!free_ok_q) begin
							free_ok_q <= 1'b1;
							fidx_q <= pa_s1;
						end
						if (last_s1) begin
							state_q <= S_DEC;
						end
					end
				end
				S_DEC: begin
					act_q <= 1'b0;
					evict_q <= 1'b0;
					ins_q <= 1'b0;
					rsp_q.hit <= hit_q;
					rsp_q.data <= (hit_q && req_q.action == lfu_pkg::ACT_GET) ? hval_q : '0;
					state_q <= S_OUT;
					if (hit_q && (req_q.action == lfu_pkg::ACT_GET || cap_q != '0)) begin
						tgt_q <= hidx_q;
						ra_q <= '0;
						cnt_q <= '0;
						state_q <= S_FIX;
					end else if (!hit_q && req_q.action == lfu_pkg::ACT_PUT && cap_q != '0) begin
						if (32'(occ_q) >= 32'(cap_eff)) begin
							if (vic_ok_q) begin
								tgt_q <= vidx_q;
								act_q <= 1'b1;
								evict_q <= 1'b1;
								ins_q <= 1'b1;
								trnk_q <= vrnk_q;
								ra_q <= '0;
								cnt_q <= '0;
								state_q <= S_FIX;
							end
						end else if (free_ok_q) begin
							tgt_q <= fidx_q;
							act_q <= 1'b1;
							ins_q <= 1'b1;
							occ_q <= occ_q + CW'(1);
							ra_q <= '0;
							cnt_q <= '0;
							state_q <= S_FIX;
						end
					end
				end
				S_FIX: begin
					if (cnt_q != CNT_END) begin
						if (ra_q != LAST) begin
							ra_q <= ra_q + IDX_W'(1);
						end
						cnt_q <= cnt_q + (IDX_W + 1)'(1);
						rd_s1 <= 1'b1;
					end
					if (rd_s1 && last_s1) begin
						state_q <= S_WR;
					end
				end
				S_WR: begin
					valid_q[tgt_q] <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!ov_q) begin
						ov_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		pa_s1 <= ra_q;
		rv_s1 <= valid_q[ra_q];
		last_s1 <= (ra_q == LAST);
	end
endmodule

/* hdl/lfu_cache_lru_tiebreak_top_chk.sv */
`include "lfu_cache_lru_tiebreak_top_assert.svh"
module lfu_cache_lru_tiebreak_top_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input lfu_pkg::rsp_t out_data
);
	`LFU_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`LFU_ASSERT_IMPL(a_no_take_busy, clk, arst_n, out_valid, !in_ready)
	`LFU_ASSERT_NEXT(a_take_busy, clk, arst_n, in_valid && in_ready, !in_ready)
	`LFU_ASSERT_IMPL(a_put_zero, clk, arst_n, out_valid && !out_data.hit, out_data.data == '0)
endmodule

bind lfu_cache_lru_tiebreak_top lfu_cache_lru_tiebreak_top_chk u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

/* tb/lfu_cache_lru_tiebreak_top_test.sv */
`timescale 1ns / 1ps

class lfu_scoreboard;
	localparam int NSLOT = 16;
	bit [4:0] capacity;
	bit slot_valid [NSLOT];
	bit [30:0] slot_key [NSLOT];
	bit [30:0] slot_value [NSLOT];
	bit [31:0] slot_count [NSLOT];
	int unsigned slot_rank [NSLOT];
	int unsigned occupancy;
	lfu_pkg::rsp_t pending [$];
	int mismatches;
	int checked;
	int hits;
	int evictions;

	function new();
		capacity = lfu_pkg::CAP_RESET;
		occupancy = 0;
		mismatches = 0;
		checked = 0;
		hits = 0;
		evictions = 0;
		for (int i = 0; i < NSLOT; i++) begin
			slot_valid[i] = 0;
		end
	endfunction

	function void promote(int e);
		for (int i = 0; i < NSLOT; i++)
			if (slot_valid[i] && slot_rank[i] < slot_rank[e])
				slot_rank[i]++;
		slot_rank[e] = 0;
		if (slot_count[e] != 32'hFFFF_FFFF)
			slot_count[e]++;
	endfunction

	function void place(bit [30:0] k, bit [30:0] v);
		int limit;
		int slot;
		limit = capacity > NSLOT ? NSLOT : capacity;
		slot = -1;
		if (occupancy >= limit) begin
			for (int i = 0; i < NSLOT; i++) begin
				if (!slot_valid[i])
					continue;
				if (slot < 0 || slot_count[i] < slot_count[slot] ||
						(slot_count[i] == slot_count[slot] && slot_rank[i] > slot_rank[slot]))
					slot = i;
			end
			if (slot < 0)
				return;
			evictions++;
			slot_valid[slot] = 0;
			for (int i = 0; i < NSLOT; i++)
				if (slot_valid[i] && slot_rank[i] > slot_rank[slot])
					slot_rank[i]--;
		end else begin
			for (int i = 0; i < NSLOT; i++)
				if (!slot_valid[i]) begin
					slot = i;
					break;
				end
			if (slot < 0)
				return;
			occupancy++;
		end
		for (int i = 0; i < NSLOT; i++)
			if (slot_valid[i])
				slot_rank[i]++;
		slot_valid[slot] = 1;
		slot_key[slot] = k;
		slot_value[slot] = v;
		slot_count[slot] = 1;
		slot_rank[slot] = 0;
	endfunction

	function void note_request(lfu_pkg::req_t r);
		int e;
		lfu_pkg::rsp_t x;
		e = -1;
		for (int i = 0; i < NSLOT; i++)
			if (e < 0 && slot_valid[i] && slot_key[i] == r.key)
				e = i;
		x.hit = (e >= 0);
		x.data = '0;
		if (r.action == lfu_pkg::ACT_GET) begin
			if (e >= 0) begin
				x.data = slot_value[e];
				promote(e);
			end
		end else if (capacity != 0) begin
			if (e >= 0) begin
				slot_value[e] = r.value;
				promote(e);
			end else begin
				place(r.key, r.value);
			end
		end
		pending.push_back(x);
	endfunction

	function void check_response(lfu_pkg::rsp_t got);
		lfu_pkg::rsp_t want;
		checked++;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result hit=%0d data=%0h", got.hit, got.data);
			return;
		end
		want = pending.pop_front();
		if (got.hit)
			hits++;
		if (got.hit !== want.hit || got.data !== want.data) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d: expected hit=%0d data=%0h, got hit=%0d data=%0h",
					checked, want.hit, want.data, got.hit, got.data);
		end
	endfunction
endclass

module lfu_cache_lru_tiebreak_top_test;
	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [lfu_pkg::CAP_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	lfu_pkg::req_t in_data;
	logic out_valid;
	logic out_ready;
	lfu_pkg::rsp_t out_data;

	lfu_scoreboard board;
	bit quiet;
	bit [30:0] key_pool [8];
	int sent;

	lfu_cache_lru_tiebreak_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial clk = 0;
	always #10 clk = ~clk;

	initial begin
		board = new();
		quiet = 0;
		cfg_we = 0;
		cfg_data = '0;
		in_valid = 0;
		in_data = '0;
		out_ready = 0;
		arst_n = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	always @(posedge clk)
		if (arst_n && in_valid && in_ready)
			board.note_request(in_data);

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			board.check_response(out_data);

	// receiver: random stall bursts
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 14);
				out_ready <= 0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1;
		end
	end

	task automatic send(bit act, bit [30:0] k, bit [30:0] v);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		in_data <= '{action: act, key: k, value: v};
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic set_capacity(bit [4:0] c);
		in_valid <= 0;
		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		cfg_data <= c;
		cfg_we <= 1;
		board.capacity = c;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic random_phase(int count, int span);
		bit [30:0] k;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0)
				k = 31'($urandom);
			else
				k = 31'(key_pool[$urandom_range(0, 7)] + $urandom_range(0, span));
			send(1'($urandom_range(0, 1)), k, 31'($urandom));
		end
	endtask

	initial begin
		sent = 0;
		@(posedge arst_n);
		@(negedge clk);
		// directed: extremes, miss, hit, update, eviction of the least frequent key
		send(lfu_pkg::ACT_GET, 31'h0, 31'h0);
		send(lfu_pkg::ACT_PUT, 31'h0, 31'h7FFF_FFFF);
		send(lfu_pkg::ACT_PUT, 31'h7FFF_FFFF, 31'h0);
		send(lfu_pkg::ACT_GET, 31'h0, 31'h1234);
		send(lfu_pkg::ACT_GET, 31'h7FFF_FFFF, 31'h0);
		send(lfu_pkg::ACT_PUT, 31'h0, 31'h5555_5555);
		send(lfu_pkg::ACT_GET, 31'h0, 31'h0);
		set_capacity(5'd2);
		send(lfu_pkg::ACT_PUT, 31'h2A2A_2A2A, 31'h2A);
		send(lfu_pkg::ACT_GET, 31'h7FFF_FFFF, 31'h0);
		send(lfu_pkg::ACT_PUT, 31'h1515_1515, 31'h15);
		send(lfu_pkg::ACT_GET, 31'h2A2A_2A2A, 31'h0);
		set_capacity(5'd0);
		send(lfu_pkg::ACT_PUT, 31'h99, 31'h1);
		send(lfu_pkg::ACT_PUT, 31'h0, 31'h2);
		send(lfu_pkg::ACT_GET, 31'h0, 31'h0);
		set_capacity(5'd31);
		for (int i = 0; i < 18; i++)
			send(lfu_pkg::ACT_PUT, 31'(31'h100 + i), 31'(31'h7000_0000 | i));
		for (int i = 0; i < 8; i++)
			key_pool[i] = 31'($urandom);
		random_phase(350, 24);
		set_capacity(5'd1);
		random_phase(200, 3);
		set_capacity(5'd4);
		random_phase(300, 8);
		set_capacity(5'd0);
		random_phase(60, 8);
		set_capacity(5'd16);
		random_phase(300, 20);
		quiet = 1;
		random_phase(150, 12);
		in_valid <= 0;
		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		$display("requests sent %0d, results checked %0d, hits %0d, evictions %0d",
			sent, board.checked, board.hits, board.evictions);
		$display("capacities 0, 1, 2, 4, 16 and 31 exercised");
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("lfu_cache_lru_tiebreak_top: match");
		else
			$display("lfu_cache_lru_tiebreak_top: mismatch");
		$finish;
	end

	initial begin
		#8ms;
		$display("lfu_cache_lru_tiebreak_top: mismatch");
		$finish;
	end
endmodule
